// ----- src/ilir_pkg.sv -----
// shared types and constants for the indexed list block
// no dependencies
package ilir_pkg;

   localparam int ILIR_DEPTH     = 16;
   localparam int ILIR_WORD_BITS = 32;

   localparam int FUNC_W      = 4;
   localparam int POS_W       = 8;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [FUNC_W-1:0] {
      FN_WRITE         = 4'd0,
      FN_GET           = 4'd1,
      FN_APPEND        = 4'd2,
      FN_INSERT        = 4'd3,
      FN_REMOVE        = 4'd4,
      FN_POP           = 4'd5,
      FN_SET_LENGTH    = 4'd6,
      FN_REMOVE_LAST_N = 4'd7,
      FN_REMOVE_RANGE  = 4'd8,
      FN_ZERO_RANGE    = 4'd9
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_ERR  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_ZERO,
      CELL_GATHER_FIRST,
      CELL_GATHER,
      CELL_COMMIT
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [POS_W-1:0]       lo;
      logic [POS_W-1:0]       hi;
   } cmd_type;

   typedef enum logic {
      S_IDLE,
      S_GATHER
   } state_type;

endpackage

// ----- src/ilir_cell.sv -----
// one list entry: stored word plus a move lane for multi-place shifts
// depends on ilir_pkg
module ilir_cell
   import ilir_pkg::*;
#(
   parameter int WORD_BITS = ILIR_WORD_BITS,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [WORD_BITS-1:0] lower_main,
   input  logic [WORD_BITS-1:0] upper_main,
   input  logic [WORD_BITS-1:0] upper_move,
   output logic [WORD_BITS-1:0] main_ff,
   output logic [WORD_BITS-1:0] move_ff
);

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic [WORD_BITS-1:0] main_in;
   logic [WORD_BITS-1:0] move_in;
   logic                 in_range;

   assign in_range = (IDX >= cmd.lo) && (IDX < cmd.hi);

   always_comb begin
      main_in = main_ff;
      move_in = move_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_WRITE: begin
            if (IDX == cmd.lo) main_in = wr_data;
         end
         CELL_INSERT: begin
            if (IDX == cmd.lo) begin
               main_in = wr_data;
            end else if ((IDX > cmd.lo) && (IDX <= cmd.hi)) begin
               main_in = lower_main;
            end
         end
         CELL_REMOVE: begin
            if (in_range) main_in = upper_main;
         end
         CELL_ZERO: begin
            if (in_range) main_in = '0;
         end
         CELL_GATHER_FIRST: begin
            move_in = upper_main;
         end
         CELL_GATHER: begin
            move_in = upper_move;
         end
         CELL_COMMIT: begin
            if (in_range) main_in = move_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= '0;
      end else begin
         main_ff <= main_in;
      end
   end

   always_ff @(posedge clock) begin
      move_ff <= move_in;
   end

endmodule

// ----- src/ilir_ctrl.sv -----
// operation decode, length register, range-removal sequencer and result register
// depends on ilir_pkg
module ilir_ctrl
   import ilir_pkg::*;
#(
   parameter int DEPTH     = ILIR_DEPTH,
   parameter int WORD_BITS = ILIR_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [POS_W-1:0]     req_position,
   input  logic [POS_W-1:0]     req_amount,
   input  logic [WORD_BITS-1:0] rd_word,
   input  logic                 rsp_tready,
   output cmd_type              cmd,
   output logic [POS_W-1:0]     rd_idx,
   output logic                 rsp_tvalid,
   output logic [DATA_W-1:0]    rsp_data_out,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_count
);

   localparam int               LEN_W   = $clog2(DEPTH + 1);
   localparam logic [POS_W-1:0] DEPTH_P = POS_W'(DEPTH);

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   lo_ff, lo_in;
   logic [POS_W-1:0]   hi_ff, hi_in;
   status_type         stat_ff, stat_in;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               req_fire;
   logic               load;
   status_type         status_v;
   func_type           fn;
   logic [POS_W-1:0]   len_p;
   logic [POS_W-1:0]   rr_end, rr_start, rr_gap;
   logic [POS_W-1:0]   zr_end, zr_start;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign fn         = func_type'(req_func);
   assign len_p      = POS_W'(len_ff);

   // clamped bounds for range removal and range zeroing
   assign rr_end   = (req_amount > len_p) ? len_p : req_amount;
   assign rr_start = (req_position > rr_end) ? rr_end : req_position;
   assign rr_gap   = rr_end - rr_start;
   assign zr_end   = (req_amount > DEPTH_P) ? DEPTH_P : req_amount;
   assign zr_start = (req_position > zr_end) ? zr_end : req_position;

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      stat_in  = stat_ff;
      cmd      = '{op: CELL_HOLD, lo: '0, hi: '0};
      rd_idx   = '1;
      load     = 1'b0;
      status_v = STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               load = 1'b1;
               unique case (fn)
                  FN_WRITE: begin
                     if (req_position >= len_p) status_v = STAT_ERR;
                     cmd = '{op: CELL_WRITE, lo: req_position, hi: '0};
                  end
                  FN_GET: begin
                     if (req_position >= len_p) status_v = STAT_ERR;
                     rd_idx = req_position;
                  end
                  FN_APPEND: begin
                     if (len_p >= DEPTH_P) begin
                        status_v = STAT_FULL;
                     end else begin
                        cmd    = '{op: CELL_WRITE, lo: len_p, hi: '0};
                        len_in = len_ff + 1'b1;
                     end
                  end
                  FN_INSERT: begin
                     if (req_position > len_p) begin
                        status_v = STAT_ERR;
                     end else if (len_p >= DEPTH_P) begin
                        status_v = STAT_FULL;
                     end else begin
                        cmd    = '{op: CELL_INSERT, lo: req_position, hi: len_p};
                        len_in = len_ff + 1'b1;
                     end
                  end
                  FN_REMOVE: begin
                     if (req_position >= len_p) begin
                        status_v = STAT_ERR;
                     end else begin
                        cmd    = '{op: CELL_REMOVE, lo: req_position, hi: len_p - 1'b1};
                        len_in = len_ff - 1'b1;
                     end
                  end
                  FN_POP: begin
                     if (len_ff == '0) begin
                        status_v = STAT_ERR;
                     end else begin
                        rd_idx = len_p - 1'b1;
                        len_in = len_ff - 1'b1;
                     end
                  end
                  FN_SET_LENGTH: begin
                     if (req_amount > DEPTH_P) begin
                        status_v = STAT_ERR;
                        len_in   = LEN_W'(DEPTH);
                     end else begin
                        len_in = LEN_W'(req_amount);
                     end
                  end
                  FN_REMOVE_LAST_N: begin
                     if (req_amount > len_p) begin
                        status_v = STAT_ERR;
                        len_in   = '0;
                     end else begin
                        len_in = LEN_W'(len_p - req_amount);
                     end
                  end
                  FN_REMOVE_RANGE: begin
                     if ((req_position >= len_p) || (req_amount > len_p)) status_v = STAT_ERR;
                     if (rr_gap != '0) begin
                        cmd      = '{op: CELL_GATHER_FIRST, lo: '0, hi: '0};
                        lo_in    = rr_start;
                        hi_in    = len_p - rr_gap;
                        cnt_in   = LEN_W'(rr_gap - 1'b1);
                        stat_in  = status_v;
                        state_in = S_GATHER;
                        load     = 1'b0;
                     end
                  end
                  FN_ZERO_RANGE: begin
                     if ((req_position >= DEPTH_P) || (req_amount > DEPTH_P)) begin
                        status_v = STAT_ERR;
                     end
                     cmd = '{op: CELL_ZERO, lo: zr_start, hi: zr_end};
                  end
                  default: begin
                     status_v = STAT_ERR;
                  end
               endcase
            end
         end
         S_GATHER: begin
            if (cnt_ff == '0) begin
               cmd      = '{op: CELL_COMMIT, lo: lo_ff, hi: hi_ff};
               len_in   = LEN_W'(hi_ff);
               status_v = stat_ff;
               load     = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd    = '{op: CELL_GATHER, lo: '0, hi: '0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      stat_ff <= stat_in;
      if (load) begin
         rsp_data_ff   <= DATA_W'(rd_word);
         rsp_status_ff <= status_v;
         rsp_count_ff  <= COUNT_W'(len_in);
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(DEPTH))
      else $error("list length above capacity");

   a_gather_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GATHER |-> !rsp_valid_ff)
      else $error("result pending during range removal");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("single-cycle operation gave no result");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GATHER && cnt_ff != '0) |=>
         (state_ff == S_GATHER && cnt_ff == LEN_W'($past(cnt_ff) - 1'b1)))
      else $error("range removal counter skipped");

   a_commit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GATHER |-> (hi_ff < len_p && lo_ff <= hi_ff))
      else $error("range removal bounds inconsistent");

endmodule

// ----- src/indexed_list_insert_remove_top.sv -----
// indexed list with insert and remove: chain of entry cells plus controller
// depends on ilir_pkg, ilir_cell, ilir_ctrl
//
// channel  dir  fields (low bit first)
// req      in   tdata: position[7:0] amount_or_end[15:8] data_in[47:16]; tuser: func
// rsp      out  tdata: data_out[31:0] status[33:32] count[38:34], bit 39 zero
//
// operations finish on acceptance, except remove range, which gathers entries through the move lanes before its commit
// result sits in an output register; the next item is taken while it is being drained
// synchronous reset clears every entry and the length
// a stalled result holds off new items until its transfer completes
module indexed_list_insert_remove_top
   import ilir_pkg::*;
#(
   parameter int DEPTH     = ILIR_DEPTH,
   parameter int WORD_BITS = ILIR_WORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // position, amount_or_end, data_in
   input  logic [FUNC_W-1:0]      req_tuser,  // func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // data_out, status, count
);

   cmd_type              cmd;
   logic [POS_W-1:0]     rd_idx;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] main_q [DEPTH];
   logic [WORD_BITS-1:0] move_q [DEPTH];
   logic [DATA_W-1:0]    data_out;
   logic [STATUS_W-1:0]  status;
   logic [COUNT_W-1:0]   count;

   assign wr_data = WORD_BITS'(req_tdata[2*POS_W +: DATA_W]);

   ilir_ctrl #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_func     (req_tuser),
      .req_position (req_tdata[0 +: POS_W]),
      .req_amount   (req_tdata[POS_W +: POS_W]),
      .rd_word      (rd_word),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .rd_idx       (rd_idx),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_data_out (data_out),
      .rsp_status   (status),
      .rsp_count    (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      logic [WORD_BITS-1:0] lower_main;
      logic [WORD_BITS-1:0] upper_main;
      logic [WORD_BITS-1:0] upper_move;

      if (i == 0) begin : g_first
         assign lower_main = '0;
      end else begin : g_mid
         assign lower_main = main_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper_main = '0;
         assign upper_move = '0;
      end else begin : g_below
         assign upper_main = main_q[i+1];
         assign upper_move = move_q[i+1];
      end

      ilir_cell #(
         .WORD_BITS (WORD_BITS),
         .INDEX     (i)
      ) u_entry (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .wr_data    (wr_data),
         .lower_main (lower_main),
         .upper_main (upper_main),
         .upper_move (upper_move),
         .main_ff    (main_q[i]),
         .move_ff    (move_q[i])
      );
   end

   // read select, zero when index is past the last cell
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (POS_W'(i) == rd_idx) rd_word = rd_word | main_q[i];
      end
   end

   assign rsp_tdata = {1'b0, count, status, data_out};

endmodule
